### design/mtep_pkg.sv
// package for the midi track event parser
// holds result codes, parse phases, protocol constants and the result item type
`timescale 1ns / 1ps

package mtep_pkg;

    localparam logic [31:0] ID_MTRK       = 32'h4D54726B;
    localparam logic [7:0]  STATUS_SYSEX  = 8'hF0;
    localparam logic [7:0]  STATUS_ESCAPE = 8'hF7;
    localparam logic [7:0]  STATUS_META   = 8'hFF;
    localparam logic [7:0]  META_END      = 8'h2F;
    localparam logic [7:0]  META_TEMPO    = 8'h51;

    localparam logic [3:0] TYPE_NOTE_OFF  = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON   = 4'h9;
    localparam logic [3:0] TYPE_POLY_AT   = 4'hA;
    localparam logic [3:0] TYPE_CONTROL   = 4'hB;
    localparam logic [3:0] TYPE_PROGRAM   = 4'hC;
    localparam logic [3:0] TYPE_CHAN_AT   = 4'hD;
    localparam logic [3:0] TYPE_PITCH     = 4'hE;

    localparam logic [3:0] KIND_NOTE_ON    = 4'd0;
    localparam logic [3:0] KIND_NOTE_OFF   = 4'd1;
    localparam logic [3:0] KIND_TEMPO      = 4'd2;
    localparam logic [3:0] KIND_END_META   = 4'd3;
    localparam logic [3:0] KIND_LENGTH_END = 4'd4;
    localparam logic [3:0] KIND_BAD_ID     = 4'd5;
    localparam logic [3:0] KIND_NO_RUNNING = 4'd6;
    localparam logic [3:0] KIND_BAD_STATUS = 4'd7;
    localparam logic [3:0] KIND_TRUNCATED  = 4'd8;

    typedef enum logic [12:0] {
        PH_IDLE    = 13'b0000000000001,
        PH_HEADER  = 13'b0000000000010,
        PH_DELTA   = 13'b0000000000100,
        PH_STATUS  = 13'b0000000001000,
        PH_DATA1   = 13'b0000000010000,
        PH_DATA2   = 13'b0000000100000,
        PH_ONE     = 13'b0000001000000,
        PH_MTYPE   = 13'b0000010000000,
        PH_MLEN    = 13'b0000100000000,
        PH_TEMPO   = 13'b0001000000000,
        PH_SKIP    = 13'b0010000000000,
        PH_SKIPEND = 13'b0100000000000,
        PH_SXLEN   = 13'b1000000000000
    } phase_t;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [31:0] event_tick;
        logic [3:0]  channel;
        logic [7:0]  note_number;
        logic [7:0]  velocity;
        logic [23:0] tempo_us_per_quarter;
        logic [15:0] track_number;
    } result_t;

endpackage

### design/mtep_if.sv
// valid/ready channel interfaces for the byte input and the event output
// depends on nothing
`timescale 1ns / 1ps

interface mtep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       track_start;

    modport source (output valid, output data_byte, output track_start, input ready);
    modport sink (input valid, input data_byte, input track_start, output ready);
endinterface

interface mtep_event_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_kind;
    logic [31:0] event_tick;
    logic [3:0]  channel;
    logic [7:0]  note_number;
    logic [7:0]  velocity;
    logic [23:0] tempo_us_per_quarter;
    logic [15:0] track_number;

    modport source (output valid, output event_kind, output event_tick, output channel,
                    output note_number, output velocity, output tempo_us_per_quarter,
                    output track_number, input ready);
    modport sink (input valid, input event_kind, input event_tick, input channel,
                  input note_number, input velocity, input tempo_us_per_quarter,
                  input track_number, output ready);
endinterface

### design/mtep_parser.sv
// input register and per-byte track parser state machine
// depends on mtep_pkg and mtep_byte_if
`timescale 1ns / 1ps

module mtep_parser (
    input  logic            clk,
    input  logic            rst_n,
    mtep_byte_if.sink       byte_ch,
    input  logic            space,
    output logic            push,
    output mtep_pkg::result_t push_item
);
    import mtep_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        advance;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hcount_reg, hcount_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  rstat_reg, rstat_next;
    logic [7:0]  cstat_reg, cstat_next;
    logic [7:0]  data1_reg, data1_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [31:0] skip_reg, skip_next;
    logic [23:0] tempo_reg, tempo_next;
    logic [15:0] tcount_reg, tcount_next;

    logic        emit;
    logic        done;
    logic        have;
    logic        bail;
    logic [31:0] len;
    logic [3:0]  kind;
    logic [3:0]  res_ch;
    logic [7:0]  res_d1;
    logic [7:0]  res_d2;
    logic [23:0] res_tempo;
    logic [31:0] res_tick;

    assign advance       = in_valid_reg && space;
    assign byte_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            in_valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
        begin
            in_byte_reg  <= byte_ch.data_byte;
            in_start_reg <= byte_ch.track_start;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        left_next   = left_reg;
        tick_next   = tick_reg;
        acc_next    = acc_reg;
        rstat_next  = rstat_reg;
        cstat_next  = cstat_reg;
        data1_next  = data1_reg;
        mtype_next  = mtype_reg;
        skip_next   = skip_reg;
        tempo_next  = tempo_reg;
        tcount_next = tcount_reg;
        emit        = 1'b0;
        done        = 1'b0;
        have        = 1'b0;
        bail        = 1'b0;
        len         = acc_reg;
        kind        = KIND_NOTE_ON;
        res_ch      = 4'd0;
        res_d1      = 8'd0;
        res_d2      = 8'd0;
        res_tempo   = 24'd0;
        res_tick    = tick_reg;

        if (in_start_reg)
        begin
            tick_next   = 32'd0;
            rstat_next  = 8'd0;
            hcount_next = 3'd0;
            acc_next    = 32'd0;
            tcount_next = tcount_reg + 16'd1;
            phase_next  = PH_HEADER;
        end
        res_tick = tick_next;

        if (phase_next == PH_HEADER)
        begin
            acc_next    = {acc_next[23:0], in_byte_reg};
            hcount_next = hcount_next + 3'd1;
            if (hcount_next == 3'd4)
            begin
                if (acc_next != ID_MTRK)
                begin
                    emit       = 1'b1;
                    kind       = KIND_BAD_ID;
                    res_tick   = 32'd0;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    acc_next = 32'd0;
                end
            end
            else if (hcount_next == 3'd0)
            begin
                left_next  = acc_next;
                acc_next   = 32'd0;
                phase_next = PH_DELTA;
                if (left_next == 32'd0)
                begin
                    emit       = 1'b1;
                    kind       = KIND_LENGTH_END;
                    phase_next = PH_IDLE;
                end
            end
        end
        else if (phase_next != PH_IDLE)
        begin
            if (left_next != 32'd0)
            begin
                left_next = left_next - 32'd1;
            end
            case (phase_next)
                PH_DELTA:
                begin
                    acc_next = {acc_next[24:0], in_byte_reg[6:0]};
                    if (!in_byte_reg[7])
                    begin
                        tick_next  = tick_next + acc_next;
                        res_tick   = tick_next;
                        acc_next   = 32'd0;
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (in_byte_reg[7])
                    begin
                        cstat_next = in_byte_reg;
                        if (in_byte_reg < STATUS_SYSEX)
                        begin
                            rstat_next = in_byte_reg;
                        end
                    end
                    else if (rstat_next == 8'd0)
                    begin
                        emit       = 1'b1;
                        kind       = KIND_NO_RUNNING;
                        phase_next = PH_IDLE;
                        bail       = 1'b1;
                    end
                    else
                    begin
                        cstat_next = rstat_next;
                        data1_next = in_byte_reg;
                        have       = 1'b1;
                    end
                    if (!bail)
                    begin
                        case (cstat_next[7:4])
                            TYPE_NOTE_OFF, TYPE_NOTE_ON, TYPE_POLY_AT, TYPE_CONTROL,
                            TYPE_PITCH:
                            begin
                                phase_next = have ? PH_DATA2 : PH_DATA1;
                            end
                            TYPE_PROGRAM, TYPE_CHAN_AT:
                            begin
                                if (have)
                                begin
                                    done       = 1'b1;
                                    phase_next = PH_DELTA;
                                end
                                else
                                begin
                                    phase_next = PH_ONE;
                                end
                            end
                            default:
                            begin
                                if (cstat_next == STATUS_META)
                                begin
                                    phase_next = PH_MTYPE;
                                end
                                else if (cstat_next == STATUS_SYSEX ||
                                         cstat_next == STATUS_ESCAPE)
                                begin
                                    acc_next   = 32'd0;
                                    phase_next = PH_SXLEN;
                                end
                                else
                                begin
                                    emit       = 1'b1;
                                    kind       = KIND_BAD_STATUS;
                                    phase_next = PH_IDLE;
                                end
                            end
                        endcase
                    end
                end
                PH_DATA1:
                begin
                    data1_next = in_byte_reg;
                    phase_next = PH_DATA2;
                end
                PH_DATA2:
                begin
                    res_ch = cstat_reg[3:0];
                    res_d1 = data1_reg;
                    res_d2 = in_byte_reg;
                    if (cstat_reg[7:4] == TYPE_NOTE_ON && in_byte_reg != 8'd0)
                    begin
                        emit = 1'b1;
                        kind = KIND_NOTE_ON;
                    end
                    else if (cstat_reg[7:4] == TYPE_NOTE_OFF ||
                             cstat_reg[7:4] == TYPE_NOTE_ON)
                    begin
                        emit = 1'b1;
                        kind = KIND_NOTE_OFF;
                    end
                    done       = 1'b1;
                    phase_next = PH_DELTA;
                end
                PH_ONE:
                begin
                    done       = 1'b1;
                    phase_next = PH_DELTA;
                end
                PH_MTYPE:
                begin
                    mtype_next = in_byte_reg;
                    acc_next   = 32'd0;
                    phase_next = PH_MLEN;
                end
                PH_MLEN, PH_SXLEN:
                begin
                    acc_next = {acc_next[24:0], in_byte_reg[6:0]};
                    if (!in_byte_reg[7])
                    begin
                        len      = acc_next;
                        acc_next = 32'd0;
                        if (phase_reg == PH_MLEN && mtype_reg == META_END)
                        begin
                            if (len == 32'd0)
                            begin
                                emit       = 1'b1;
                                kind       = KIND_END_META;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                skip_next  = len;
                                phase_next = PH_SKIPEND;
                            end
                        end
                        else if (phase_reg == PH_MLEN && mtype_reg == META_TEMPO &&
                                 len == 32'd3)
                        begin
                            skip_next  = 32'd3;
                            tempo_next = 24'd0;
                            phase_next = PH_TEMPO;
                        end
                        else if (len == 32'd0)
                        begin
                            done       = 1'b1;
                            phase_next = PH_DELTA;
                        end
                        else
                        begin
                            skip_next  = len;
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_TEMPO:
                begin
                    tempo_next = {tempo_reg[15:0], in_byte_reg};
                    skip_next  = skip_reg - 32'd1;
                    if (skip_next == 32'd0)
                    begin
                        emit       = 1'b1;
                        kind       = KIND_TEMPO;
                        res_tempo  = tempo_next;
                        done       = 1'b1;
                        phase_next = PH_DELTA;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_next == 32'd0)
                    begin
                        done       = 1'b1;
                        phase_next = PH_DELTA;
                    end
                end
                PH_SKIPEND:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_next == 32'd0)
                    begin
                        emit       = 1'b1;
                        kind       = KIND_END_META;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (phase_next != PH_IDLE && left_next == 32'd0)
            begin
                if (!done)
                begin
                    emit   = 1'b1;
                    kind   = KIND_TRUNCATED;
                    res_ch = 4'd0;
                    res_d1 = 8'd0;
                    res_d2 = 8'd0;
                end
                else if (!emit)
                begin
                    emit   = 1'b1;
                    kind   = KIND_LENGTH_END;
                    res_ch = 4'd0;
                    res_d1 = 8'd0;
                    res_d2 = 8'd0;
                end
                phase_next = PH_IDLE;
            end
        end

        if (!emit || (kind != KIND_NOTE_ON && kind != KIND_NOTE_OFF))
        begin
            res_ch = 4'd0;
            res_d1 = 8'd0;
            res_d2 = 8'd0;
        end
    end

    assign push                           = advance && emit;
    assign push_item.event_kind           = kind;
    assign push_item.event_tick           = res_tick;
    assign push_item.channel              = res_ch;
    assign push_item.note_number          = res_d1;
    assign push_item.velocity             = res_d2;
    assign push_item.tempo_us_per_quarter = res_tempo;
    assign push_item.track_number         = tcount_next - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            hcount_reg <= 3'd0;
            left_reg   <= 32'd0;
            tick_reg   <= 32'd0;
            acc_reg    <= 32'd0;
            rstat_reg  <= 8'd0;
            cstat_reg  <= 8'd0;
            data1_reg  <= 8'd0;
            mtype_reg  <= 8'd0;
            skip_reg   <= 32'd0;
            tempo_reg  <= 24'd0;
            tcount_reg <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            left_reg   <= left_next;
            tick_reg   <= tick_next;
            acc_reg    <= acc_next;
            rstat_reg  <= rstat_next;
            cstat_reg  <= cstat_next;
            data1_reg  <= data1_next;
            mtype_reg  <= mtype_next;
            skip_reg   <= skip_next;
            tempo_reg  <= tempo_next;
            tcount_reg <= tcount_next;
        end
    end

endmodule

### design/mtep_out_buf.sv
// two-entry result buffer that drives the event channel
// depends on mtep_pkg and mtep_event_if
`timescale 1ns / 1ps

module mtep_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mtep_pkg::result_t push_item,
    output logic              space,
    mtep_event_if.source      event_ch
);
    import mtep_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;
    logic [1:0] widx;

    assign pop   = (count_reg != 2'd0) && event_ch.ready;
    assign space = (count_reg != 2'd2);
    assign widx  = count_reg - {1'b0, pop};

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
        end
        if (push)
        begin
            if (widx[0])
            begin
                slot1_next = push_item;
            end
            else
            begin
                slot0_next = push_item;
            end
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign event_ch.valid                = (count_reg != 2'd0);
    assign event_ch.event_kind           = slot0_reg.event_kind;
    assign event_ch.event_tick           = slot0_reg.event_tick;
    assign event_ch.channel              = slot0_reg.channel;
    assign event_ch.note_number          = slot0_reg.note_number;
    assign event_ch.velocity             = slot0_reg.velocity;
    assign event_ch.tempo_us_per_quarter = slot0_reg.tempo_us_per_quarter;
    assign event_ch.track_number         = slot0_reg.track_number;

endmodule

### design/midi_track_event_parser.sv
// an accepted byte is held in the input register, then parsed into the two-entry
// result buffer; throughput: one byte per cycle while the result buffer has space,
// with the parse step between input register and result buffer
// reset: rst_n clears all parse state and empties both registers; no clearing pass
// depends on mtep_pkg, mtep_if, mtep_parser and mtep_out_buf
`timescale 1ns / 1ps

module midi_track_event_parser (
    input  logic         clk,
    input  logic         rst_n,
    mtep_byte_if.sink    byte_ch,
    mtep_event_if.source event_ch
);
    import mtep_pkg::*;

    logic    space;
    logic    push;
    result_t push_item;

    mtep_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .space     (space),
        .push      (push),
        .push_item (push_item)
    );

    mtep_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .space     (space),
        .event_ch  (event_ch)
    );

endmodule

### design/mtep_checker.sv
// port-level assertions for the midi track event parser, bound to the top level
// depends on mtep_pkg
`timescale 1ns / 1ps

module mtep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  event_kind,
    input logic [31:0] event_tick,
    input logic [3:0]  channel,
    input logic [7:0]  note_number,
    input logic [7:0]  velocity,
    input logic [23:0] tempo_us_per_quarter
);
    import mtep_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("item dropped while stalled");

    a_hold_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(event_kind) && $stable(event_tick))
        else $error("item changed while stalled");

    a_note_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != KIND_NOTE_ON && event_kind != KIND_NOTE_OFF
        |-> channel == 4'd0 && note_number == 8'd0 && velocity == 8'd0)
        else $error("note fields set on a non-note item");

    a_tempo_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != KIND_TEMPO |-> tempo_us_per_quarter == 24'd0)
        else $error("tempo set on a non-tempo item");

    a_bad_id_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == KIND_BAD_ID |-> event_tick == 32'd0)
        else $error("bad id item with nonzero tick");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .out_valid            (event_ch.valid),
    .out_ready            (event_ch.ready),
    .event_kind           (event_ch.event_kind),
    .event_tick           (event_ch.event_tick),
    .channel              (event_ch.channel),
    .note_number          (event_ch.note_number),
    .velocity             (event_ch.velocity),
    .tempo_us_per_quarter (event_ch.tempo_us_per_quarter)
);

### dv/mtep_event_checker.sv
// checker for the midi track event parser: predicts each event from the accepted
// bytes, compares accepted events field by field and counts failures
// depends on mtep_pkg and the byte and event channel interfaces
`timescale 1ns / 1ps

module mtep_event_checker (
    input  logic        clk,
    input  logic        rst_n,
    mtep_byte_if        byte_ch,
    mtep_event_if       event_ch,
    output int unsigned fail_count,
    output int unsigned pending
);

    import mtep_pkg::*;

    phase_t      phase;
    logic [2:0]  hdr_cnt;
    logic [31:0] bytes_left;
    logic [31:0] tick;
    logic [31:0] accum;
    logic [7:0]  running;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  meta_type;
    logic [31:0] skip_cnt;
    logic [23:0] tempo;
    logic [15:0] track_cnt;

    result_t expected_events[$];
    result_t want;
    result_t ev;
    bit      emitted;

    initial fail_count = 0;

    task automatic report_error(input string msg);
        if (fail_count < 100)
            $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_error($sformatf("%s got %0h want %0h", name, got, exp_val));
    endtask

    function automatic result_t make_event(input logic [3:0] kind, input logic [31:0] t,
                                           input logic [3:0] ch, input logic [7:0] d1,
                                           input logic [7:0] d2, input logic [23:0] tp);
        result_t r;
        r.event_kind           = kind;
        r.event_tick           = t;
        r.channel              = ch;
        r.note_number          = d1;
        r.velocity             = d2;
        r.tempo_us_per_quarter = tp;
        r.track_number         = track_cnt - 16'd1;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic start,
                              output bit has_event, output result_t r);
        bit          done;
        bit          have;
        logic [3:0]  ty;
        logic [31:0] len;
        done      = 1'b0;
        have      = 1'b0;
        has_event = 1'b0;
        r         = '0;
        if (start)
        begin
            tick      = 32'd0;
            running   = 8'd0;
            hdr_cnt   = 3'd0;
            accum     = 32'd0;
            track_cnt = track_cnt + 16'd1;
            phase     = PH_HEADER;
        end
        if (phase == PH_IDLE)
            return;
        if (phase == PH_HEADER)
        begin
            accum   = {accum[23:0], b};
            hdr_cnt = hdr_cnt + 3'd1;
            if (hdr_cnt == 3'd4)
            begin
                if (accum != ID_MTRK)
                begin
                    r         = make_event(KIND_BAD_ID, 32'd0, 4'd0, 8'd0, 8'd0, 24'd0);
                    has_event = 1'b1;
                    phase     = PH_IDLE;
                end
                else
                    accum = 32'd0;
            end
            else if (hdr_cnt == 3'd0)
            begin
                bytes_left = accum;
                accum      = 32'd0;
                phase      = PH_DELTA;
                if (bytes_left == 32'd0)
                begin
                    r         = make_event(KIND_LENGTH_END, tick, 4'd0, 8'd0, 8'd0, 24'd0);
                    has_event = 1'b1;
                    phase     = PH_IDLE;
                end
            end
            return;
        end
        if (bytes_left != 32'd0)
            bytes_left = bytes_left - 32'd1;
        case (phase)
            PH_DELTA:
            begin
                accum = {accum[24:0], b[6:0]};
                if (!b[7])
                begin
                    tick  = tick + accum;
                    accum = 32'd0;
                    phase = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (b[7])
                begin
                    status = b;
                    if (b < STATUS_SYSEX)
                        running = b;
                end
                else if (running == 8'd0)
                begin
                    r         = make_event(KIND_NO_RUNNING, tick, 4'd0, 8'd0, 8'd0, 24'd0);
                    has_event = 1'b1;
                    phase     = PH_IDLE;
                end
                else
                begin
                    status = running;
                    data1  = b;
                    have   = 1'b1;
                end
                if (!has_event)
                begin
                    ty = status[7:4];
                    case (ty)
                        TYPE_NOTE_OFF, TYPE_NOTE_ON, TYPE_POLY_AT, TYPE_CONTROL, TYPE_PITCH:
                            phase = have ? PH_DATA2 : PH_DATA1;
                        TYPE_PROGRAM, TYPE_CHAN_AT:
                        begin
                            if (have)
                            begin
                                done  = 1'b1;
                                phase = PH_DELTA;
                            end
                            else
                                phase = PH_ONE;
                        end
                        default:
                        begin
                            if (status == STATUS_META)
                                phase = PH_MTYPE;
                            else if (status == STATUS_SYSEX || status == STATUS_ESCAPE)
                            begin
                                accum = 32'd0;
                                phase = PH_SXLEN;
                            end
                            else
                            begin
                                r = make_event(KIND_BAD_STATUS, tick, 4'd0, 8'd0, 8'd0, 24'd0);
                                has_event = 1'b1;
                                phase     = PH_IDLE;
                            end
                        end
                    endcase
                end
            end
            PH_DATA1:
            begin
                data1 = b;
                phase = PH_DATA2;
            end
            PH_DATA2:
            begin
                ty = status[7:4];
                if (ty == TYPE_NOTE_ON && b != 8'd0)
                begin
                    r         = make_event(KIND_NOTE_ON, tick, status[3:0], data1, b, 24'd0);
                    has_event = 1'b1;
                end
                else if (ty == TYPE_NOTE_OFF || ty == TYPE_NOTE_ON)
                begin
                    r         = make_event(KIND_NOTE_OFF, tick, status[3:0], data1, b, 24'd0);
                    has_event = 1'b1;
                end
                done  = 1'b1;
                phase = PH_DELTA;
            end
            PH_ONE:
            begin
                done  = 1'b1;
                phase = PH_DELTA;
            end
            PH_MTYPE:
            begin
                meta_type = b;
                accum     = 32'd0;
                phase     = PH_MLEN;
            end
            PH_MLEN, PH_SXLEN:
            begin
                accum = {accum[24:0], b[6:0]};
                if (!b[7])
                begin
                    len   = accum;
                    accum = 32'd0;
                    if (phase == PH_MLEN && meta_type == META_END)
                    begin
                        if (len == 32'd0)
                        begin
                            r = make_event(KIND_END_META, tick, 4'd0, 8'd0, 8'd0, 24'd0);
                            has_event = 1'b1;
                            phase     = PH_IDLE;
                        end
                        else
                        begin
                            skip_cnt = len;
                            phase    = PH_SKIPEND;
                        end
                    end
                    else if (phase == PH_MLEN && meta_type == META_TEMPO && len == 32'd3)
                    begin
                        skip_cnt = 32'd3;
                        tempo    = 24'd0;
                        phase    = PH_TEMPO;
                    end
                    else if (len == 32'd0)
                    begin
                        done  = 1'b1;
                        phase = PH_DELTA;
                    end
                    else
                    begin
                        skip_cnt = len;
                        phase    = PH_SKIP;
                    end
                end
            end
            PH_TEMPO:
            begin
                tempo    = {tempo[15:0], b};
                skip_cnt = skip_cnt - 32'd1;
                if (skip_cnt == 32'd0)
                begin
                    r         = make_event(KIND_TEMPO, tick, 4'd0, 8'd0, 8'd0, tempo);
                    has_event = 1'b1;
                    done      = 1'b1;
                    phase     = PH_DELTA;
                end
            end
            PH_SKIP:
            begin
                skip_cnt = skip_cnt - 32'd1;
                if (skip_cnt == 32'd0)
                begin
                    done  = 1'b1;
                    phase = PH_DELTA;
                end
            end
            PH_SKIPEND:
            begin
                skip_cnt = skip_cnt - 32'd1;
                if (skip_cnt == 32'd0)
                begin
                    r         = make_event(KIND_END_META, tick, 4'd0, 8'd0, 8'd0, 24'd0);
                    has_event = 1'b1;
                    phase     = PH_IDLE;
                end
            end
            default:
                phase = PH_IDLE;
        endcase
        // chunk length used up
        if (phase != PH_IDLE && bytes_left == 32'd0)
        begin
            if (!done)
            begin
                r         = make_event(KIND_TRUNCATED, tick, 4'd0, 8'd0, 8'd0, 24'd0);
                has_event = 1'b1;
            end
            else if (!has_event)
            begin
                r         = make_event(KIND_LENGTH_END, tick, 4'd0, 8'd0, 8'd0, 24'd0);
                has_event = 1'b1;
            end
            phase = PH_IDLE;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase      = PH_IDLE;
            hdr_cnt    = 3'd0;
            bytes_left = 32'd0;
            tick       = 32'd0;
            accum      = 32'd0;
            running    = 8'd0;
            status     = 8'd0;
            data1      = 8'd0;
            meta_type  = 8'd0;
            skip_cnt   = 32'd0;
            tempo      = 24'd0;
            track_cnt  = 16'd0;
            expected_events.delete();
            pending <= 0;
        end
        else
        begin
            if (event_ch.valid && event_ch.ready)
            begin
                if (expected_events.size() == 0)
                    report_error($sformatf("event kind %0d with nothing expected",
                                           event_ch.event_kind));
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", event_ch.event_kind, want.event_kind);
                    check_field("event_tick", event_ch.event_tick, want.event_tick);
                    check_field("channel", event_ch.channel, want.channel);
                    check_field("note_number", event_ch.note_number, want.note_number);
                    check_field("velocity", event_ch.velocity, want.velocity);
                    check_field("tempo_us_per_quarter", event_ch.tempo_us_per_quarter,
                                want.tempo_us_per_quarter);
                    check_field("track_number", event_ch.track_number, want.track_number);
                end
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                parse_byte(byte_ch.data_byte, byte_ch.track_start, emitted, ev);
                if (emitted)
                    expected_events = {expected_events, ev};
            end
            pending <= expected_events.size();
        end
    end

endmodule

### dv/tb_top.sv
// top of the midi track event parser testbench: clock, reset, track byte stimulus
// with bursts and gaps, event receiver stalls, final verdict
// depends on mtep_pkg, the channel interfaces, the parser and mtep_event_checker
`timescale 1ns / 1ps

module tb_top;

    import mtep_pkg::*;

    logic clk;
    logic rst_n;

    mtep_byte_if  byte_ch ();
    mtep_event_if event_ch ();

    int unsigned fail_count;
    int unsigned pending_events;

    logic [8:0]  stim_q[$];
    logic [7:0]  body_q[$];
    logic [7:0]  gen_running;
    int unsigned burst_left;
    int unsigned random_items;
    int unsigned drain_cycles;
    int unsigned ready_cycle;

    midi_track_event_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .event_ch (event_ch)
    );

    mtep_event_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .event_ch   (event_ch),
        .fail_count (fail_count),
        .pending    (pending_events)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver stall pattern
    initial
    begin
        event_ch.ready = 1'b0;
        ready_cycle    = 0;
        forever
        begin
            @(posedge clk);
            ready_cycle++;
            case ((ready_cycle / 97) % 4)
                0:       event_ch.ready <= 1'b1;
                1:       event_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       event_ch.ready <= ((ready_cycle % 7) < 4);
                default: event_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic add_body(input logic [7:0] b);
        body_q = {body_q, b};
    endtask

    task automatic add_stim(input logic [8:0] item);
        stim_q = {stim_q, item};
    endtask

    task automatic put_vlq(input logic [31:0] value, input int unsigned pad);
        logic [7:0]  groups[$];
        logic [31:0] rest;
        rest = value >> 7;
        groups.push_front({1'b0, value[6:0]});
        while (rest != 0)
        begin
            groups.push_front({1'b1, rest[6:0]});
            rest = rest >> 7;
        end
        repeat (pad) add_body(8'h80);
        foreach (groups[i]) add_body(groups[i]);
    endtask

    task automatic put_delta();
        case ($urandom_range(0, 9))
            0, 1, 2: put_vlq(32'd0, 0);
            3, 4, 5: put_vlq($urandom_range(1, 127), 0);
            6:       put_vlq($urandom_range(128, 32'h001F_FFFF), $urandom_range(0, 1));
            7:       put_vlq($urandom(), 0);
            8:       put_vlq(32'h0FFF_FFFF, 0);
            default:
            begin
                // long number, wraps at 32 bits
                repeat ($urandom_range(1, 4))
                    add_body(8'h80 | 8'($urandom_range(0, 127)));
                put_vlq($urandom_range(0, 127), 0);
            end
        endcase
    endtask

    task automatic put_channel_event();
        logic [7:0] st;
        logic [7:0] d1;
        logic [7:0] d2;
        bit         use_run;
        st      = 8'h80 + 8'($urandom_range(0, 111));
        use_run = (gen_running != 8'd0) && ($urandom_range(0, 2) == 0);
        if (use_run)
            st = gen_running;
        else
        begin
            add_body(st);
            gen_running = st;
        end
        d1 = 8'($urandom_range(0, 127));
        if (!use_run && $urandom_range(0, 7) == 0)
            d1[7] = 1'b1;
        add_body(d1);
        if (st[7:4] != TYPE_PROGRAM && st[7:4] != TYPE_CHAN_AT)
        begin
            case ($urandom_range(0, 9))
                0:       d2 = 8'd0;
                1:       d2 = 8'($urandom_range(0, 255));
                default: d2 = 8'($urandom_range(1, 127));
            endcase
            add_body(d2);
        end
    endtask

    task automatic put_meta_event();
        int unsigned len;
        logic [7:0]  mtype;
        case ($urandom_range(0, 3))
            0:
            begin
                add_body(STATUS_META);
                add_body(META_TEMPO);
                add_body(8'd3);
                case ($urandom_range(0, 3))
                    0:       repeat (3) add_body(8'h00);
                    1:       repeat (3) add_body(8'hFF);
                    default: repeat (3) add_body(8'($urandom_range(0, 255)));
                endcase
            end
            1:
            begin
                mtype = 8'($urandom_range(0, 255));
                if (mtype == META_END)
                    mtype = META_TEMPO;
                len = $urandom_range(0, 5);
                add_body(STATUS_META);
                add_body(mtype);
                put_vlq(len, 0);
                repeat (len) add_body(8'($urandom_range(0, 255)));
            end
            default:
            begin
                add_body($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE);
                len = $urandom_range(0, 5);
                put_vlq(len, $urandom_range(0, 1));
                repeat (len) add_body(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic put_end_of_track();
        int unsigned len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        add_body(STATUS_META);
        add_body(META_END);
        put_vlq(len, 0);
        repeat (len) add_body(8'($urandom_range(0, 255)));
    endtask

    task automatic queue_header(input logic [31:0] id, input logic [31:0] length_field);
        add_stim({1'b1, id[31:24]});
        add_stim({1'b0, id[23:16]});
        add_stim({1'b0, id[15:8]});
        add_stim({1'b0, id[7:0]});
        add_stim({1'b0, length_field[31:24]});
        add_stim({1'b0, length_field[23:16]});
        add_stim({1'b0, length_field[15:8]});
        add_stim({1'b0, length_field[7:0]});
    endtask

    task automatic add_track();
        int unsigned pick;
        int unsigned body_len;
        int unsigned keep;
        logic [31:0] id;
        logic [31:0] length_field;
        bit          broken;
        body_q.delete();
        gen_running = 8'd0;
        broken      = 1'b0;
        repeat ($urandom_range(1, 8))
        begin
            if (!broken)
            begin
                put_delta();
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    put_channel_event();
                else if (pick < 19)
                    put_meta_event();
                else
                begin
                    // bad status (or the escape F7) or a data byte with no status byte before it
                    if ($urandom_range(0, 1))
                        add_body(8'hF1 + 8'($urandom_range(0, 13)));
                    else
                        add_body(8'($urandom_range(0, 127)));
                    broken = 1'b1;
                end
            end
        end
        if (!broken && $urandom_range(0, 3) < 2)
            put_end_of_track();
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) add_body(8'($urandom_range(0, 255)));
        body_len = body_q.size();
        case ($urandom_range(0, 9))
            7:       length_field = $urandom_range(0, body_len - 1);
            8:       length_field = body_len + $urandom_range(1, 4);
            9:       length_field = $urandom();
            default: length_field = body_len;
        endcase
        id = ID_MTRK;
        if ($urandom_range(0, 11) == 0)
            id = id ^ (32'd1 << $urandom_range(0, 31));
        queue_header(id, length_field);
        // sometimes the next track starts in the middle of this one
        keep = body_len;
        if ($urandom_range(0, 11) == 0)
            keep = $urandom_range(0, body_len);
        foreach (body_q[i])
            if (i < keep)
                add_stim({1'b0, body_q[i]});
    endtask

    task automatic send_item(input logic [8:0] item);
        if (burst_left == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= item[7:0];
        byte_ch.track_start <= item[8];
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        burst_left--;
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events != 0);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = 8'd0;
        byte_ch.track_start = 1'b0;
        burst_left          = 0;
        random_items        = 0;
        drain_cycles        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty chunk, bad id, ignored idle byte, bad status
        stim_q.delete();
        queue_header(ID_MTRK, 32'd0);
        queue_header(ID_MTRK ^ 32'd1, 32'hFFFF_FFFF);
        add_stim({1'b0, 8'hFF});
        queue_header(ID_MTRK, 32'd2);
        add_stim({1'b0, 8'h00});
        add_stim({1'b0, 8'hF4});
        foreach (stim_q[i]) send_item(stim_q[i]);
        wait_drained();

        while (random_items < 850)
        begin
            stim_q.delete();
            add_track();
            random_items += stim_q.size();
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) add_stim({1'b0, 8'($urandom_range(0, 255))});
            foreach (stim_q[i]) send_item(stim_q[i]);
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end

        byte_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
            drain_cycles++;
        end
        while (pending_events != 0 && drain_cycles < 20000);
        repeat (16) @(posedge clk);
        if (pending_events == 0 && fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
design/mtep_pkg.sv
design/mtep_if.sv
design/mtep_parser.sv
design/mtep_out_buf.sv
design/midi_track_event_parser.sv
design/mtep_checker.sv
dv/mtep_event_checker.sv
dv/tb_top.sv
